// ===== rtl/gri_pkg.sv =====
package gri_pkg;

    // Value format: unsigned Q1.16, 65536 stands for 1.0.
    localparam int VW = 17;
    localparam int FRAC_BITS = 16;
    localparam logic [VW-1:0] ONE_Q16 = 17'h10000;

    localparam int GRI_MAX_STOPS = 8;
    localparam int GRI_MAX_COMPONENTS = 5;
    localparam int NUM_OUTPUTS = 5;

    // Fraction divider: FRAC_BITS quotient bits, DIV_STEP bits per stage.
    localparam int DIV_STEP = 2;
    localparam int DIV_STAGES = FRAC_BITS / DIV_STEP;

    // Stream payload layout.
    localparam int IDX_W = 3;
    localparam int IN_DATA_W = 128;
    localparam int OUT_DATA_W = 88;
    localparam int IN_LOC_LSB = IDX_W;
    localparam int IN_COL_LSB = IN_LOC_LSB + VW;
    localparam int IN_POS_LSB = IN_COL_LSB + NUM_OUTPUTS * VW;

    // Configuration port.
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-1:0] REG_STOP_COUNT = 3'd0;
    localparam logic [ADDR_W-1:0] REG_COMPONENTS = 3'd4;
    localparam logic [3:0] STOP_COUNT_RESET = 4'd0;
    localparam logic [2:0] COMPONENTS_RESET = 3'd4;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } opcode_t;

    typedef logic [VW-1:0] val_t;
    typedef logic [NUM_OUTPUTS-1:0][VW-1:0] out_vec_t;

endpackage

// ===== rtl/gradient_ramp_interpolator_top.sv =====
// Piecewise linear colour ramp.
// Input stream (s_*): tuser carries the opcode. A load request writes one stop
// (location and colour components); an evaluate request carries a position and
// returns one interpolated colour on the result stream (m_*), or nothing when no
// stops are in use. Loads never return anything.
// Configuration over the APB port: stop_count at 0x0, components_per_colour at
// 0x4, to be written by the user only while idle; the block does not check it.
// The datapath is a 13-stage pipeline: input register, stop search, colour read,
// eight divider stages of two quotient bits each, a multiply stage and the
// output register. One request can enter every cycle unless the output stalls;
// throughput is set by the divider pipeline and is one item per cycle.
// The whole pipeline advances as one whenever the output register is empty or
// being taken, so a stall on m_tready freezes every stage and s_tready drops in
// the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and sets stop_count to 0 and
// components_per_colour to 4. Stop contents are not cleared and must be loaded
// before they are used.
module gradient_ramp_interpolator_top
    import gri_pkg::*;
#(
    parameter int MAX_STOPS = GRI_MAX_STOPS,
    parameter int MAX_COMPONENTS = GRI_MAX_COMPONENTS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // stop_index[2:0], stop_location[19:3], stop_colour_0..4[104:20],
    // position[121:105], zero fill above
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // opcode[0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // colour_0[16:0], colour_1[33:17], colour_2[50:34], colour_3[67:51],
    // colour_4[84:68], zero fill above
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int SW = $clog2(MAX_STOPS);
    localparam int CNTW = $clog2(MAX_STOPS + 1);

    typedef logic [MAX_COMPONENTS-1:0][VW-1:0] comp_vec_t;

    // Configuration registers.
    logic [3:0] stop_count_reg;
    logic [2:0] comps_reg;
    logic       cfg_write;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_count_reg <= STOP_COUNT_RESET;
            comps_reg <= COMPONENTS_RESET;
        end else if (cfg_write) begin
            unique case (paddr)
                REG_STOP_COUNT: stop_count_reg <= pwdata[3:0];
                REG_COMPONENTS: comps_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            REG_STOP_COUNT: prdata = {28'd0, stop_count_reg};
            REG_COMPONENTS: prdata = {29'd0, comps_reg};
            default:        prdata = 32'd0;
        endcase
    end

    logic [CNTW-1:0] count_eff;
    logic [2:0]      comps_eff;

    always_comb begin
        if (int'(stop_count_reg) > MAX_STOPS) begin
            count_eff = CNTW'(MAX_STOPS);
        end else begin
            count_eff = CNTW'(stop_count_reg);
        end
        if (int'(comps_reg) > MAX_COMPONENTS) begin
            comps_eff = 3'(MAX_COMPONENTS);
        end else begin
            comps_eff = comps_reg;
        end
    end

    logic adv;
    logic m_tvalid_reg;

    assign adv = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // Stage 1: input register.
    logic             v1_reg;
    opcode_t          op1_reg;
    logic [IDX_W-1:0] idx1_reg;
    val_t             loc1_reg;
    val_t             t1_reg;
    comp_vec_t        cols1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op1_reg <= opcode_t'(s_tuser);
            idx1_reg <= s_tdata[IDX_W-1:0];
            loc1_reg <= s_tdata[IN_LOC_LSB +: VW];
            t1_reg <= s_tdata[IN_POS_LSB +: VW];
            for (int i = 0; i < MAX_COMPONENTS; i++) begin
                cols1_reg[i] <= s_tdata[IN_COL_LSB + i * VW +: VW];
            end
        end
    end

    // Stage 2: stop search. Locations are written here so that searches and
    // loads see the store in request order.
    val_t            loc_mem_reg [MAX_STOPS];
    logic            ld1_ok;
    logic [SW-1:0]   upper_next;
    logic [SW-1:0]   lower_next;

    assign ld1_ok = v1_reg && (op1_reg == OP_LOAD) && (int'(idx1_reg) < MAX_STOPS);

    always_comb begin
        upper_next = SW'(count_eff - CNTW'(1));
        for (int u = MAX_STOPS - 1; u >= 1; u--) begin
            if (u < int'(count_eff) && loc_mem_reg[u] >= t1_reg) begin
                upper_next = SW'(u);
            end
        end
        lower_next = (upper_next != '0) ? upper_next - SW'(1) : '0;
    end

    logic          v2_reg;
    logic          ld2_reg;
    logic [SW-1:0] idx2_reg;
    logic [SW-1:0] lo2_reg;
    logic [SW-1:0] up2_reg;
    val_t          t2_reg;
    val_t          a2_reg;
    val_t          b2_reg;
    comp_vec_t     cols2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            ld2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg && (op1_reg == OP_EVAL) && (count_eff != '0);
            ld2_reg <= ld1_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (ld1_ok) begin
                loc_mem_reg[SW'(idx1_reg)] <= loc1_reg;
            end
            a2_reg <= loc_mem_reg[lower_next];
            b2_reg <= loc_mem_reg[upper_next];
            lo2_reg <= lower_next;
            up2_reg <= upper_next;
            t2_reg <= t1_reg;
            idx2_reg <= SW'(idx1_reg);
            cols2_reg <= cols1_reg;
        end
    end

    // Stage 3: colour read and fraction set-up.
    comp_vec_t col_mem_reg [MAX_STOPS];
    comp_vec_t from_row_reg;
    comp_vec_t to_row_reg;
    logic      v3_reg;

    logic [DIV_STAGES:0]   dv_v;
    logic [DIV_STAGES:0]   dv_zero;
    logic [DIV_STAGES:0]   dv_sat;
    val_t                  dv_rem [DIV_STAGES+1];
    val_t                  dv_d [DIV_STAGES+1];
    logic [FRAC_BITS-1:0]  dv_q [DIV_STAGES+1];
    out_vec_t              dv_from [DIV_STAGES+1];
    out_vec_t              dv_to [DIV_STAGES+1];

    logic zero3_reg_b;
    logic sat3_reg;
    val_t n3_reg;
    val_t d3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (ld2_reg) begin
                col_mem_reg[idx2_reg] <= cols2_reg;
            end
            from_row_reg <= col_mem_reg[lo2_reg];
            to_row_reg <= col_mem_reg[up2_reg];
            zero3_reg_b <= (b2_reg <= a2_reg) || (t2_reg <= a2_reg);
            sat3_reg <= (t2_reg - a2_reg) >= (b2_reg - a2_reg);
            n3_reg <= t2_reg - a2_reg;
            d3_reg <= b2_reg - a2_reg;
        end
    end

    // Unused components are forced to zero before the divider carries them.
    genvar g;
    generate
        for (g = 0; g < NUM_OUTPUTS; g++) begin : g_expand
            if (g < MAX_COMPONENTS) begin : g_used
                assign dv_from[0][g] = (g < int'(comps_eff)) ? from_row_reg[g] : '0;
                assign dv_to[0][g] = (g < int'(comps_eff)) ? to_row_reg[g] : '0;
            end else begin : g_unused
                assign dv_from[0][g] = '0;
                assign dv_to[0][g] = '0;
            end
        end
    endgenerate

    assign dv_v[0] = v3_reg;
    assign dv_zero[0] = zero3_reg_b;
    assign dv_sat[0] = sat3_reg;
    assign dv_rem[0] = n3_reg;
    assign dv_d[0] = d3_reg;
    assign dv_q[0] = '0;

    // Restoring divider: the remainder stays below the divisor, so each step
    // doubles it and subtracts the divisor where it fits.
    generate
        for (g = 0; g < DIV_STAGES; g++) begin : g_div
            val_t                 rem_next;
            logic [FRAC_BITS-1:0] q_next;
            logic [VW:0]          dbl;

            always_comb begin
                rem_next = dv_rem[g];
                q_next = dv_q[g];
                dbl = '0;
                for (int j = 0; j < DIV_STEP; j++) begin
                    dbl = {rem_next, 1'b0};
                    if (dbl >= {1'b0, dv_d[g]}) begin
                        rem_next = VW'(dbl - {1'b0, dv_d[g]});
                        q_next = {q_next[FRAC_BITS-2:0], 1'b1};
                    end else begin
                        rem_next = dbl[VW-1:0];
                        q_next = {q_next[FRAC_BITS-2:0], 1'b0};
                    end
                end
            end

            logic     v_reg;
            logic     zero_reg;
            logic     sat_reg;
            val_t     rem_reg;
            val_t     d_reg;
            logic [FRAC_BITS-1:0] q_reg;
            out_vec_t from_reg;
            out_vec_t to_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg <= 1'b0;
                end else if (adv) begin
                    v_reg <= dv_v[g];
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    zero_reg <= dv_zero[g];
                    sat_reg <= dv_sat[g];
                    rem_reg <= rem_next;
                    d_reg <= dv_d[g];
                    q_reg <= q_next;
                    from_reg <= dv_from[g];
                    to_reg <= dv_to[g];
                end
            end

            assign dv_v[g+1] = v_reg;
            assign dv_zero[g+1] = zero_reg;
            assign dv_sat[g+1] = sat_reg;
            assign dv_rem[g+1] = rem_reg;
            assign dv_d[g+1] = d_reg;
            assign dv_q[g+1] = q_reg;
            assign dv_from[g+1] = from_reg;
            assign dv_to[g+1] = to_reg;
        end
    endgenerate

    // Multiply stage.
    val_t        frac;
    val_t        frac_inv;
    logic        vm_reg;
    logic [2*VW-1:0] pa_reg [NUM_OUTPUTS];
    logic [2*VW-1:0] pb_reg [NUM_OUTPUTS];

    always_comb begin
        if (dv_zero[DIV_STAGES]) begin
            frac = '0;
        end else if (dv_sat[DIV_STAGES]) begin
            frac = ONE_Q16;
        end else begin
            frac = {1'b0, dv_q[DIV_STAGES]};
        end
        frac_inv = ONE_Q16 - frac;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm_reg <= 1'b0;
        end else if (adv) begin
            vm_reg <= dv_v[DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NUM_OUTPUTS; i++) begin
                pa_reg[i] <= dv_from[DIV_STAGES][i] * frac_inv;
                pb_reg[i] <= dv_to[DIV_STAGES][i] * frac;
            end
        end
    end

    // Output register.
    out_vec_t         out_reg;
    logic [2*VW:0]    sum [NUM_OUTPUTS];

    always_comb begin
        for (int i = 0; i < NUM_OUTPUTS; i++) begin
            sum[i] = {1'b0, pa_reg[i]} + {1'b0, pb_reg[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= vm_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NUM_OUTPUTS; i++) begin
                out_reg[i] <= sum[i][FRAC_BITS +: VW];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {{(OUT_DATA_W - NUM_OUTPUTS * VW){1'b0}}, out_reg};

endmodule

// ===== rtl/gri_checker.sv =====
module gri_checker
    import gri_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // The pipeline moves as one: input is taken exactly when the output
    // register is free.
    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow the output register");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_fill_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_DATA_W-1:NUM_OUTPUTS*VW] == '0)
        else $error("fill bits of result not zero");

endmodule

bind gradient_ramp_interpolator_top gri_checker u_gri_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
